// ===== hw/rtl/apnt_pkg.sv =====
// ----------------------------------------------------------------------------
// apnt_pkg
// Shared codes and control types for the affine point and normal transform.
// ----------------------------------------------------------------------------
`default_nettype none

package apnt_pkg;

    // Request codes carried in the input tuser
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_POINT  = 2'd1;
    localparam logic [1:0] REQ_NORMAL = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    // Result kinds
    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_NORMAL = 1'b1;

    // Normal magnitudes are scaled into [2^NORM_LO_EXP, 2^NORM_HI_EXP)
    localparam int NORM_LO_EXP = 29;
    localparam int NORM_HI_EXP = 30;
    localparam int SQRT_STEPS  = 32;
    localparam int CNT_W       = 5;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_fe_status;

    typedef struct packed {
        logic start;
        logic ack;
    } t_nu_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_nu_status;

endpackage

`default_nettype wire

// ===== hw/rtl/apnt_front.sv =====
// ----------------------------------------------------------------------------
// apnt_front
// Accepts requests, holds the coefficient matrix, and forms the rounded
// 3x3 products (plus translation and clipping for points) in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module apnt_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int EW         = 50
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [3:0]            i_coef_index,
    input  wire logic [DATA_WIDTH-1:0] i_coef_value,
    input  wire logic [DATA_WIDTH-1:0] i_x,
    input  wire logic [DATA_WIDTH-1:0] i_y,
    input  wire logic [DATA_WIDTH-1:0] i_z,
    output apnt_pkg::t_fe_status       o_status,
    output logic                       o_push,
    output logic [3*EW+1:0]            o_push_data
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2*DW + 2;
    localparam int RW = SW - F;
    localparam int PW = EW + 1;
    localparam logic signed [DW-1:0] ONE = DW'(64'd1 << F);
    localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
    localparam logic signed [PW-1:0] SAT_MAX = $signed(PW'({1'b0, {(DW-1){1'b1}}}));
    localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

    logic signed [DW-1:0]   r_coef [16];
    logic                   r_s1_valid;
    logic                   r_s1_kind;
    logic signed [2*DW-1:0] r_p [3][3];
    logic signed [DW-1:0]   r_t [3];
    logic                   r_s2_valid;
    logic                   r_s2_kind;
    logic                   r_s2_flag;
    logic signed [EW-1:0]   r_s2_v [3];

    logic signed [DW-1:0]   w_in [3];
    logic signed [SW-1:0]   w_sum [3];
    logic signed [RW-1:0]   w_r [3];
    logic signed [PW-1:0]   w_pt [3];
    logic signed [EW-1:0]   n_v [3];
    logic [2:0]             w_clip;
    logic                   w_xform;

    assign w_in[0] = $signed(i_x);
    assign w_in[1] = $signed(i_y);
    assign w_in[2] = $signed(i_z);
    assign w_xform = i_accept && (i_req_type == apnt_pkg::REQ_POINT ||
                                  i_req_type == apnt_pkg::REQ_NORMAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_coef[k] <= (k % 5 == 0) ? ONE : '0;
            end
        end else if (i_accept && i_req_type == apnt_pkg::REQ_LOAD) begin
            r_coef[i_coef_index] <= $signed(i_coef_value);
        end
    end

    // Stage 1: nine products against the matrix as it stands at this transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_xform;
        end
        if (w_xform) begin
            r_s1_kind <= (i_req_type == apnt_pkg::REQ_NORMAL) ?
                         apnt_pkg::KIND_NORMAL : apnt_pkg::KIND_POINT;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= w_in[j] * r_coef[4*j + i];
                end
                r_t[i] <= r_coef[12 + i];
            end
        end
    end

    // Stage 2: round once, then translate and clip points
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = SW'(r_p[i][0]) + SW'(r_p[i][1]) + SW'(r_p[i][2]) + HALF;
            w_r[i]   = $signed(w_sum[i][SW-1:F]);
            w_pt[i]  = PW'(w_r[i]) + PW'(r_t[i]);
            w_clip[i] = 1'b0;
            if (r_s1_kind == apnt_pkg::KIND_NORMAL) begin
                n_v[i] = EW'(w_r[i]);
            end else if (w_pt[i] > SAT_MAX) begin
                n_v[i] = EW'(SAT_MAX);
                w_clip[i] = 1'b1;
            end else if (w_pt[i] < SAT_MIN) begin
                n_v[i] = EW'(SAT_MIN);
                w_clip[i] = 1'b1;
            end else begin
                n_v[i] = EW'(w_pt[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_s2_kind <= r_s1_kind;
            r_s2_flag <= |w_clip;
            for (int i = 0; i < 3; i++) begin
                r_s2_v[i] <= n_v[i];
            end
        end
    end

    assign o_status.s1_valid = r_s1_valid;
    assign o_status.s2_valid = r_s2_valid;
    assign o_push      = r_s2_valid;
    assign o_push_data = {r_s2_flag, r_s2_kind, r_s2_v[2], r_s2_v[1], r_s2_v[0]};

endmodule

`default_nettype wire

// ===== hw/rtl/apnt_fifo.sv =====
// ----------------------------------------------------------------------------
// apnt_fifo
// Short queue between the front stages and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module apnt_fifo #(
    parameter int WIDTH      = 102,
    parameter int DEPTH_LOG2 = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [WIDTH-1:0]      i_data,
    input  wire logic                  i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_valid,
    output logic [DEPTH_LOG2:0]        o_count
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wptr;
    logic [DEPTH_LOG2-1:0] r_rptr;
    logic [DEPTH_LOG2:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (DEPTH_LOG2+1)'(i_push) - (DEPTH_LOG2+1)'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/apnt_norm.sv =====
// ----------------------------------------------------------------------------
// apnt_norm
// Scales a linear-transformed normal to unit length: bit-serial scaling,
// squared length, restoring square root and three parallel dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module apnt_norm #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int EW         = 50
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire apnt_pkg::t_nu_ctrl    i_ctrl,
    input  wire logic [3*EW-1:0]       i_vec,
    output apnt_pkg::t_nu_status       o_status,
    output logic [3*DATA_WIDTH-1:0]    o_vec,
    output logic                       o_flag
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = (EW > 31) ? EW : 31;
    localparam int LO = apnt_pkg::NORM_LO_EXP;
    localparam int HI = apnt_pkg::NORM_HI_EXP;
    localparam int NW = HI + F + 1;
    localparam int QW = F + 1;
    localparam int VW = ((F + 2 > DW) ? F + 2 : DW) + 1;
    localparam logic signed [VW-1:0] SAT_MAX = $signed(VW'({1'b0, {(DW-1){1'b1}}}));
    localparam logic signed [VW-1:0] SAT_MIN = -SAT_MAX - VW'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_SQ    = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_DINIT = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                 r_state;
    logic [apnt_pkg::CNT_W-1:0] r_cnt;
    logic [2:0]                 r_neg;
    logic [MW-1:0]              r_mag [3];
    logic [2*HI-1:0]            r_sq [3];
    logic [63:0]                r_n;
    logic [63:0]                r_res;
    logic [F:0]                 r_num [3];
    logic [31:0]                r_rem [3];
    logic [QW-1:0]              r_q [3];

    logic signed [EW-1:0] w_v [3];
    logic [EW-1:0]        w_abs [3];
    logic [MW-1:0]        w_mx;
    logic [63:0]          w_bit;
    logic [63:0]          w_try;
    logic [30:0]          w_len;
    logic [NW-1:0]        w_num [3];
    logic [32:0]          w_trial [3];
    logic signed [VW-1:0] w_s [3];
    logic [2:0]           w_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]   = $signed(i_vec[i*EW +: EW]);
            w_abs[i] = w_v[i][EW-1] ? EW'(-w_v[i]) : EW'(w_v[i]);
        end
        w_mx = r_mag[0];
        if (r_mag[1] > w_mx) begin
            w_mx = r_mag[1];
        end
        if (r_mag[2] > w_mx) begin
            w_mx = r_mag[2];
        end
        w_bit = 64'd1 << (7'd62 - {1'b0, r_cnt, 1'b0});
        w_try = r_res + w_bit;
        w_len = r_res[30:0];
        for (int i = 0; i < 3; i++) begin
            w_num[i]   = (NW'(r_mag[i][HI-1:0]) << F) + NW'(w_len >> 1);
            w_trial[i] = {r_rem[i], r_num[i][F]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctrl.start) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (w_mx == '0) begin
                        r_state <= ST_DONE;
                    end else if (w_mx[MW-1:HI] == '0 && w_mx[LO]) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_state <= ST_SQRT;
                    r_cnt   <= '0;
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == apnt_pkg::CNT_W'(apnt_pkg::SQRT_STEPS - 1)) begin
                        r_state <= ST_DINIT;
                    end
                end
                ST_DINIT: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == apnt_pkg::CNT_W'(F)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_ctrl.ack) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= w_v[i][EW-1];
                    r_mag[i] <= MW'(w_abs[i]);
                end
            end
            ST_SCALE: begin
                // One bit per cycle toward the target octave; zero clears the quotients
                for (int i = 0; i < 3; i++) begin
                    if (w_mx == '0) begin
                        r_q[i] <= '0;
                    end else if (w_mx[MW-1:HI] != '0) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (!w_mx[LO]) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            ST_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= r_mag[i][HI-1:0] * r_mag[i][HI-1:0];
                end
            end
            ST_SUM: begin
                r_n   <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
                r_res <= '0;
            end
            ST_SQRT: begin
                if (r_n >= w_try) begin
                    r_n   <= r_n - w_try;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            ST_DINIT: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= 32'(w_num[i][NW-1:F+1]);
                    r_num[i] <= w_num[i][F:0];
                    r_q[i]   <= '0;
                end
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_num[i] <= r_num[i] << 1;
                    if (w_trial[i] >= 33'(w_len)) begin
                        r_rem[i] <= 32'(w_trial[i] - 33'(w_len));
                        r_q[i]   <= {r_q[i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= w_trial[i][31:0];
                        r_q[i]   <= {r_q[i][QW-2:0], 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s[i] = r_neg[i] ? -$signed(VW'(r_q[i])) : $signed(VW'(r_q[i]));
            w_clip[i] = 1'b0;
            if (w_s[i] > SAT_MAX) begin
                w_s[i] = SAT_MAX;
                w_clip[i] = 1'b1;
            end else if (w_s[i] < SAT_MIN) begin
                w_s[i] = SAT_MIN;
                w_clip[i] = 1'b1;
            end
            o_vec[i*DW +: DW] = w_s[i][DW-1:0];
        end
    end

    assign o_flag          = |w_clip;
    assign o_status.busy   = (r_state != ST_IDLE);
    assign o_status.done   = (r_state == ST_DONE);

endmodule

`default_nettype wire

// ===== hw/rtl/affine_point_normal_transform_core.sv =====
// ----------------------------------------------------------------------------
// affine_point_normal_transform_core
// Streams 3D points and normals through a stored 4x4 column-major matrix.
// ----------------------------------------------------------------------------
// Input stream (s_*): one request per transfer; s_tuser is the request type
// (load coefficient, transform point, transform normal). Loads update the
// matrix in order with the stream and give no result; type 3 is dropped.
// Output stream (m_*): one result per point or normal, in request order.
// Points: a new request every cycle while s_tready is high; a result passes
// through the product stage, the rounding stage, the queue and the output
// register in turn.
// Normals: bit-serial scaling, the squared length, the square root and the
// dividers, in that order, give the result at Q16.16; the normal unit
// handles one at a time and later results wait behind it. Requests keep
// entering the queue meanwhile.
// Reset restores the identity matrix and empties the pipeline and queue.
// When m_tready is low the output register holds; the queue fills and
// s_tready drops only when the queue and front stages reach their credit.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_normal_transform_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // coef_index, coef_value, in_x, in_y, in_z, zero pad
    input  wire logic [((4*DATA_WIDTH+4+7)/8)*8-1:0] s_tdata,
    // req_type
    input  wire logic [1:0]              s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // out_x, out_y, out_z
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // result_kind, saturated
    output logic [1:0]                   m_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int OUT_TW = ((3*DW + 7) / 8) * 8;
    localparam int RW     = 2*DW + 2 - FRAC_BITS;
    localparam int EW     = (RW > DW) ? RW : DW;
    localparam int QW     = 3*EW + 2;
    localparam int QLOG2  = 3;
    localparam int QDEPTH = 1 << QLOG2;

    apnt_pkg::t_fe_status w_fe_status;
    apnt_pkg::t_nu_ctrl   w_nu_ctrl;
    apnt_pkg::t_nu_status w_nu_status;

    logic              w_accept;
    logic              w_push;
    logic [QW-1:0]     w_push_data;
    logic              w_pop;
    logic [QW-1:0]     w_head;
    logic              w_head_valid;
    logic [QLOG2:0]    w_count;
    logic [QLOG2+1:0]  w_credit;
    logic [3*DW-1:0]   w_nu_vec;
    logic              w_nu_flag;
    logic              w_out_free;
    logic              w_load_pt;
    logic              w_load_nu;
    logic [3*DW-1:0]   w_pt_vec;

    logic              r_out_valid;
    logic [3*DW-1:0]   r_out_vec;
    logic [1:0]        r_out_user;

    // Count everything that may still land in the queue
    assign w_credit = (QLOG2+2)'(w_count) + (QLOG2+2)'(w_fe_status.s1_valid)
                    + (QLOG2+2)'(w_fe_status.s2_valid);
    assign s_tready = (w_credit < (QLOG2+2)'(QDEPTH));
    assign w_accept = s_tvalid && s_tready;

    apnt_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (s_tuser),
        .i_coef_index (s_tdata[3:0]),
        .i_coef_value (s_tdata[4 +: DW]),
        .i_x          (s_tdata[4+DW +: DW]),
        .i_y          (s_tdata[4+2*DW +: DW]),
        .i_z          (s_tdata[4+3*DW +: DW]),
        .o_status     (w_fe_status),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    apnt_fifo #(
        .WIDTH      (QW),
        .DEPTH_LOG2 (QLOG2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_valid (w_head_valid),
        .o_count (w_count)
    );

    apnt_norm #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW)
    ) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_nu_ctrl),
        .i_vec    (w_head[3*EW-1:0]),
        .o_status (w_nu_status),
        .o_vec    (w_nu_vec),
        .o_flag   (w_nu_flag)
    );

    // Dispatch the queue head in order; a normal in flight holds all later items
    always_comb begin
        w_out_free      = !r_out_valid || m_tready;
        w_load_nu       = w_nu_status.done && w_out_free;
        w_load_pt       = 1'b0;
        w_nu_ctrl.start = 1'b0;
        w_nu_ctrl.ack   = w_load_nu;
        if (w_head_valid && !w_nu_status.busy) begin
            if (w_head[3*EW] == apnt_pkg::KIND_NORMAL) begin
                w_nu_ctrl.start = 1'b1;
            end else begin
                w_load_pt = w_out_free;
            end
        end
        w_pop = w_load_pt || w_nu_ctrl.start;
        for (int i = 0; i < 3; i++) begin
            w_pt_vec[i*DW +: DW] = w_head[i*EW +: DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_pt || w_load_nu) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_nu) begin
            r_out_vec  <= w_nu_vec;
            r_out_user <= {w_nu_flag, apnt_pkg::KIND_NORMAL};
        end else if (w_load_pt) begin
            r_out_vec  <= w_pt_vec;
            r_out_user <= {w_head[3*EW+1], apnt_pkg::KIND_POINT};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_TW'(r_out_vec);
    assign m_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== bench/affine_point_normal_transform_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_point_normal_transform_core_test
// Streams coefficient loads, points and normals into the transform core and
// compares every result against a local bit-exact model of the datapath or a directed entry.
// A directed table comes first, then weighted random traffic, under three
// backpressure profiles and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_normal_transform_core_test;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic        kind;
        logic        sat;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
    } t_result;

    typedef struct {
        logic [1:0]  req;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          typed;
        t_result     res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;  // coef_index, coef_value, in_x, in_y, in_z, pad
    logic [1:0]   s_tuser = apnt_pkg::REQ_LOAD;  // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;  // out_x, out_y, out_z
    logic [1:0]   m_tuser;  // result_kind, saturated

    affine_point_normal_transform_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 i_clk = ~i_clk;

    logic signed [31:0] matrix_q [16];
    t_result            pending_results [$];
    t_row               directed [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 loads_sent = 0, points_sent = 0, normals_sent = 0, sat_seen = 0;
    int                 send_idle_pct = 8, recv_idle_pct = 75;
    bit                 hold_req = 1'b0, hold_done = 1'b0;
    int                 hold_cnt = 0;

    // ---------------------------------------------------------------- model
    function automatic logic signed [71:0] dot3(input logic signed [71:0] a0, b0,
                                                input logic signed [71:0] a1, b1,
                                                input logic signed [71:0] a2, b2);
        return (a0 * b0 + a1 * b1 + a2 * b2 + (72'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic logic [31:0] clip32(input logic signed [71:0] v, inout logic f);
        if (v > 72'sd2147483647) begin
            f = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -72'sd2147483648) begin
            f = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_result transform_vector(input logic [1:0] req,
                                                 input logic signed [31:0] x, y, z);
        t_result            o;
        logic signed [71:0] r [3];
        logic [71:0]        mag [3];
        logic [71:0]        peak;
        logic [63:0]        len, q;
        logic               f;
        f = 1'b0;
        for (int i = 0; i < 3; i++)
            r[i] = dot3(x, matrix_q[i], y, matrix_q[4+i], z, matrix_q[8+i]);
        o.kind = (req == apnt_pkg::REQ_NORMAL) ? apnt_pkg::KIND_NORMAL : apnt_pkg::KIND_POINT;
        if (req == apnt_pkg::REQ_POINT) begin
            o.ox = clip32(r[0] + matrix_q[12], f);
            o.oy = clip32(r[1] + matrix_q[13], f);
            o.oz = clip32(r[2] + matrix_q[14], f);
        end else begin
            peak = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = r[i][71] ? -r[i] : r[i];
                if (mag[i] > peak) peak = mag[i];
            end
            if (peak == 0) begin
                o.ox = 0; o.oy = 0; o.oz = 0;
            end else begin
                while (peak >= (72'd1 << apnt_pkg::NORM_HI_EXP)) begin
                    peak = peak >> 1;
                    for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
                end
                while (peak < (72'd1 << apnt_pkg::NORM_LO_EXP)) begin
                    peak = peak << 1;
                    for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                end
                len = isqrt64(mag[0][63:0] * mag[0][63:0] + mag[1][63:0] * mag[1][63:0]
                              + mag[2][63:0] * mag[2][63:0]);
                for (int i = 0; i < 3; i++) begin
                    q = ((mag[i][63:0] << FB) + (len >> 1)) / len;
                    r[i] = r[i][71] ? -$signed({8'd0, q}) : $signed({8'd0, q});
                end
                o.ox = clip32(r[0], f);
                o.oy = clip32(r[1], f);
                o.oz = clip32(r[2], f);
            end
        end
        o.sat = f;
        return o;
    endfunction

    // ------------------------------------------------------------- stimulus
    task automatic send_request(input t_row rw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rw.req;
        s_tdata  <= {4'd0, rw.z, rw.y, rw.x, rw.val, rw.idx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        case (rw.req)
            apnt_pkg::REQ_LOAD: begin
                matrix_q[rw.idx] = rw.val;
                loads_sent++;
            end
            apnt_pkg::REQ_POINT, apnt_pkg::REQ_NORMAL: begin
                if (rw.req == apnt_pkg::REQ_POINT) points_sent++;
                else normals_sent++;
                pending_results.push_back(rw.typed ? rw.res
                                          : transform_vector(rw.req, rw.x, rw.y, rw.z));
            end
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [1:0] req, input logic [3:0] idx,
                           input logic [31:0] val, x, y, z,
                           input bit typed, input t_result res);
        t_row rw;
        rw.req = req; rw.idx = idx; rw.val = val;
        rw.x = x; rw.y = y; rw.z = z;
        rw.typed = typed; rw.res = res;
        directed.push_back(rw);
    endtask

    function automatic logic [31:0] rand_q(input int shape);
        case (shape)
            0: return $urandom();
            1: return $signed($urandom_range(2 * 262144)) - 262144;  // +-4.0
            2: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(2 * 65536)) - 65536;  // +-1.0
        endcase
    endfunction

    initial begin
        t_row    rw;
        t_result none;
        int      w;
        none = '0;
        for (int i = 0; i < 16; i++) matrix_q[i] = (i % 5 == 0) ? (32'sd1 <<< FB) : 0;

        // identity after reset
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 1,
                '{apnt_pkg::KIND_POINT, 1'b0, 32'h1_0000, 32'h2_0000, 32'h3_0000});
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 32'h3_0000, 0, 0, 1,
                '{apnt_pkg::KIND_NORMAL, 1'b0, 32'h1_0000, 0, 0});
        // zero-length normal comes back as zero
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 0, 0, 0, 1,
                '{apnt_pkg::KIND_NORMAL, 1'b0, 0, 0, 0});
        // reserved type is dropped
        add_row(apnt_pkg::REQ_RSVD, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 0, none);
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                0, none);
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                0, none);
        // extreme translation saturates both ways
        add_row(apnt_pkg::REQ_LOAD, 12, 32'h7fff_ffff, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 13, 32'h8000_0000, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 14, 32'h1_0000, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'h1_0000, 32'hffff_0000, 0, 1,
                '{apnt_pkg::KIND_POINT, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h1_0000});
        add_row(apnt_pkg::REQ_LOAD, 15, 32'hdead_beef, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 0, 32'h8000_0000, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 5, 32'h7fff_ffff, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                0, none);
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                0, none);
        // half-LSB products round upward
        add_row(apnt_pkg::REQ_LOAD, 0, 32'h0000_8000, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 12, 0, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_LOAD, 13, 0, 0, 0, 0, 0, none);
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 0, none);
        add_row(apnt_pkg::REQ_POINT, 0, 0, 32'hffff_ffff, 32'h1, 32'h3, 0, none);
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 32'hffff_fffd, 32'h1, 32'h0, 0, none);
        add_row(apnt_pkg::REQ_NORMAL, 0, 0, 32'h0000_0001, 32'h0, 32'h0, 0, none);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_request(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 75; recv_idle_pct = 8;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (n == 2 * RANDOM_ITEMS / 3 + 50) hold_req = 1'b1;
            w = $urandom_range(99);
            rw.req   = (w < 25) ? apnt_pkg::REQ_LOAD : (w < 65) ? apnt_pkg::REQ_POINT
                       : (w < 97) ? apnt_pkg::REQ_NORMAL : apnt_pkg::REQ_RSVD;
            rw.idx   = $urandom_range(15);
            rw.val   = rand_q($urandom_range(3));
            w        = $urandom_range(3);
            rw.x     = rand_q(w);
            rw.y     = rand_q(w);
            rw.z     = rand_q($urandom_range(3));
            rw.typed = 0;
            rw.res   = none;
            send_request(rw);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d loads, %0d points, %0d normals; checked %0d results (%0d saturated).",
                 loads_sent, points_sent, normals_sent, results_seen, sat_seen);
        $display("Backpressure profiles: slow sender, slow receiver, none, plus a long hold-off.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("affine_point_normal_transform_core_test: PASS");
        end else begin
            $display("affine_point_normal_transform_core_test: FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------- sink
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            // stall the output long enough for the input to back up
            m_tready  <= 1'b0;
            hold_cnt  <= 600;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tuser[1], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
            results_seen++;
            if (got.sat) sat_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d x=%h y=%h z=%h sat=%0d",
                             got.kind, got.ox, got.oy, got.oz, got.sat);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d exp kind=%0d x=%h y=%h z=%h sat=%0d",
                                 results_seen, want.kind, want.ox, want.oy, want.oz,
                                 want.sat);
                        $display("       got kind=%0d x=%h y=%h z=%h sat=%0d",
                                 got.kind, got.ox, got.oy, got.oz, got.sat);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("affine_point_normal_transform_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/apnt_pkg.sv
hw/rtl/apnt_front.sv
hw/rtl/apnt_fifo.sv
hw/rtl/apnt_norm.sv
hw/rtl/affine_point_normal_transform_core.sv
bench/affine_point_normal_transform_core_test.sv
